// File: hw/rtl/lsts_pkg.sv
package lsts_pkg;

	localparam int unsigned TimeWidth   = 32;
	localparam int unsigned FactorWidth = 16;
	localparam int unsigned StateWidth  = 3;
	localparam int unsigned CfgIdxWidth = 3;
	localparam int unsigned Latency     = 3;

	typedef enum logic [StateWidth-1:0] {
		LINK_PENDING   = 3'd0,
		LINK_HANDSHAKE = 3'd1,
		LINK_ACTIVE    = 3'd2,
		LINK_STALE     = 3'd3,
		LINK_CLOSED    = 3'd4,
		LINK_OPEN      = 3'd5
	} link_state_t;

	typedef enum logic [CfgIdxWidth-1:0] {
		CFG_HANDSHAKE_LIMIT   = 3'd0,
		CFG_IDLE_LIMIT        = 3'd1,
		CFG_LIFETIME_LIMIT    = 3'd2,
		CFG_STALE_GRACE       = 3'd3,
		CFG_KEEPALIVE_FACTOR  = 3'd4,
		CFG_CLOSED_KEEP_LIMIT = 3'd5
	} cfg_index_t;

endpackage

// File: hw/rtl/link_session_timeout_supervisor.sv
// Checks one session record per cycle against the current time and reports its close,
// flush, keepalive, stale and removal decisions. A record is taken on any cycle with start
// high; busy stays low, so a table can be swept at one record per clock. The decisions for
// a record appear on the result ports exactly three cycles later for one cycle, marked by
// done, and must be captured then since they cannot be held off. The three stages are the
// base-time selection with the round trip product, the age subtractions with the stale
// deadline sum, and the limit compares. Configuration writes are always ready and should
// only be made while no records are in flight.
module link_session_timeout_supervisor (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [lsts_pkg::StateWidth-1:0]      link_state,
	input  logic                                 is_initiator,
	input  logic [lsts_pkg::TimeWidth-1:0]       time_now,
	input  logic [lsts_pkg::TimeWidth-1:0]       time_created,
	input  logic [lsts_pkg::TimeWidth-1:0]       last_rx_time,
	input  logic [lsts_pkg::TimeWidth-1:0]       last_tx_time,
	input  logic [lsts_pkg::TimeWidth-1:0]       last_keepalive_time,
	input  logic [lsts_pkg::TimeWidth-1:0]       keepalive_period,
	input  logic [lsts_pkg::TimeWidth-1:0]       stale_limit,
	input  logic [lsts_pkg::TimeWidth-1:0]       round_trip_ms,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lsts_pkg::CfgIdxWidth-1:0]     cfg_index,
	input  logic [lsts_pkg::TimeWidth-1:0]       cfg_data,
	output logic                                 done,
	output logic                                 close_due,
	output logic                                 flush_deferred,
	output logic                                 keepalive_due,
	output logic                                 stale_due,
	output logic                                 remove_due
);

	localparam int unsigned TW = lsts_pkg::TimeWidth;

	logic [TW-1:0]                       handshake_limit_q;
	logic [TW-1:0]                       idle_limit_q;
	logic [TW-1:0]                       lifetime_limit_q;
	logic [TW-1:0]                       stale_grace_q;
	logic [lsts_pkg::FactorWidth-1:0]    keepalive_factor_q;
	logic [TW-1:0]                       closed_keep_limit_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handshake_limit_q   <= '0;
			idle_limit_q        <= '0;
			lifetime_limit_q    <= '0;
			stale_grace_q       <= '0;
			keepalive_factor_q  <= '0;
			closed_keep_limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (lsts_pkg::cfg_index_t'(cfg_index))
				lsts_pkg::CFG_HANDSHAKE_LIMIT:   handshake_limit_q   <= cfg_data;
				lsts_pkg::CFG_IDLE_LIMIT:        idle_limit_q        <= cfg_data;
				lsts_pkg::CFG_LIFETIME_LIMIT:    lifetime_limit_q    <= cfg_data;
				lsts_pkg::CFG_STALE_GRACE:       stale_grace_q       <= cfg_data;
				lsts_pkg::CFG_KEEPALIVE_FACTOR:
					keepalive_factor_q <= cfg_data[lsts_pkg::FactorWidth-1:0];
				lsts_pkg::CFG_CLOSED_KEEP_LIMIT: closed_keep_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Stage 1: base times, round trip product and stale plus grace.
	logic [TW-1:0] last_c;
	logic [TW-1:0] rtt_prod_c;

	assign last_c     = (last_rx_time > last_tx_time) ? last_rx_time : last_tx_time;
	assign rtt_prod_c = round_trip_ms * TW'(keepalive_factor_q);

	logic                               valid_s1;
	logic [lsts_pkg::StateWidth-1:0]    state_s1;
	logic                               init_s1;
	logic [TW-1:0]                      now_s1;
	logic [TW-1:0]                      created_s1;
	logic [TW-1:0]                      act_base_s1;
	logic [TW-1:0]                      in_base_s1;
	logic [TW-1:0]                      tx_s1;
	logic [TW-1:0]                      ka_s1;
	logic                               ka_never_s1;
	logic [TW-1:0]                      period_s1;
	logic [TW-1:0]                      stale_s1;
	logic [TW-1:0]                      rtt_prod_s1;
	logic [TW-1:0]                      stale_grace_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		state_s1       <= link_state;
		init_s1        <= is_initiator;
		now_s1         <= time_now;
		created_s1     <= time_created;
		act_base_s1    <= (last_c == '0) ? time_created : last_c;
		in_base_s1     <= (last_rx_time == '0) ? time_created : last_rx_time;
		tx_s1          <= last_tx_time;
		ka_s1          <= last_keepalive_time;
		ka_never_s1    <= (last_keepalive_time == '0);
		period_s1      <= keepalive_period;
		stale_s1       <= stale_limit;
		rtt_prod_s1    <= rtt_prod_c;
		stale_grace_s1 <= stale_limit + stale_grace_q;
	end

	// Stage 2: wrapping ages and the stale close deadline.
	logic                               valid_s2;
	logic [lsts_pkg::StateWidth-1:0]    state_s2;
	logic                               init_s2;
	logic [TW-1:0]                      act_age_s2;
	logic [TW-1:0]                      in_age_s2;
	logic [TW-1:0]                      life_age_s2;
	logic [TW-1:0]                      out_age_s2;
	logic [TW-1:0]                      ka_age_s2;
	logic                               ka_never_s2;
	logic [TW-1:0]                      period_s2;
	logic [TW-1:0]                      stale_s2;
	logic [TW-1:0]                      deadline_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		state_s2    <= state_s1;
		init_s2     <= init_s1;
		act_age_s2  <= now_s1 - act_base_s1;
		in_age_s2   <= now_s1 - in_base_s1;
		life_age_s2 <= now_s1 - created_s1;
		out_age_s2  <= now_s1 - tx_s1;
		ka_age_s2   <= now_s1 - ka_s1;
		ka_never_s2 <= ka_never_s1;
		period_s2   <= period_s1;
		stale_s2    <= stale_s1;
		deadline_s2 <= stale_grace_s1 + rtt_prod_s1;
	end

	// Stage 3: limit compares and per-state decisions.
	logic close_c;
	logic flush_c;
	logic keep_c;
	logic mark_c;
	logic remove_c;
	logic open_expired_c;

	assign open_expired_c = (act_age_s2 > idle_limit_q) || (life_age_s2 > lifetime_limit_q);

	always_comb begin
		close_c  = 1'b0;
		flush_c  = 1'b0;
		keep_c   = 1'b0;
		mark_c   = 1'b0;
		remove_c = open_expired_c;
		case (lsts_pkg::link_state_t'(state_s2))
			lsts_pkg::LINK_PENDING, lsts_pkg::LINK_HANDSHAKE: begin
				close_c  = act_age_s2 > handshake_limit_q;
				remove_c = act_age_s2 > handshake_limit_q;
			end
			lsts_pkg::LINK_ACTIVE: begin
				flush_c = 1'b1;
				keep_c  = init_s2 && (period_s2 != '0)
					&& ((in_age_s2 >= period_s2) || (out_age_s2 >= period_s2))
					&& (ka_never_s2 || (ka_age_s2 >= period_s2));
				mark_c  = (stale_s2 != '0) && (in_age_s2 >= stale_s2);
			end
			lsts_pkg::LINK_STALE: begin
				close_c  = in_age_s2 >= deadline_s2;
				remove_c = act_age_s2 > idle_limit_q;
			end
			lsts_pkg::LINK_CLOSED: begin
				remove_c = act_age_s2 > closed_keep_limit_q;
			end
			default: begin
				close_c = open_expired_c;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		close_due      <= close_c;
		flush_deferred <= flush_c;
		keepalive_due  <= keep_c;
		stale_due      <= mark_c;
		remove_due     <= remove_c;
	end

endmodule

// File: hw/rtl/lsts_checker.sv
module lsts_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic close_due,
	input logic flush_deferred,
	input logic keepalive_due,
	input logic stale_due
);

	// Every accepted record yields a result marked by done.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted record produced no result");

	// No result appears without a record accepted at the matching time.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without an accepted record");

	// Only active sessions ask for keepalive or stale marking, and they never close.
	a_active_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (keepalive_due || stale_due)) |-> flush_deferred)
		else $error("keepalive or stale outside the active state");

	a_active_no_close: assert property (@(posedge clk) disable iff (!arst_n)
		(done && flush_deferred) |-> !close_due)
		else $error("active session reported for close");

endmodule

bind link_session_timeout_supervisor lsts_checker u_lsts_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.close_due      (close_due),
	.flush_deferred (flush_deferred),
	.keepalive_due  (keepalive_due),
	.stale_due      (stale_due)
);

// File: dv/lsts_decision_checker.sv
module lsts_decision_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic [lsts_pkg::StateWidth-1:0]  link_state,
	input  logic                             is_initiator,
	input  logic [lsts_pkg::TimeWidth-1:0]   time_now,
	input  logic [lsts_pkg::TimeWidth-1:0]   time_created,
	input  logic [lsts_pkg::TimeWidth-1:0]   last_rx_time,
	input  logic [lsts_pkg::TimeWidth-1:0]   last_tx_time,
	input  logic [lsts_pkg::TimeWidth-1:0]   last_keepalive_time,
	input  logic [lsts_pkg::TimeWidth-1:0]   keepalive_period,
	input  logic [lsts_pkg::TimeWidth-1:0]   stale_limit,
	input  logic [lsts_pkg::TimeWidth-1:0]   round_trip_ms,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [lsts_pkg::CfgIdxWidth-1:0] cfg_index,
	input  logic [lsts_pkg::TimeWidth-1:0]   cfg_data,
	input  logic                             done,
	input  logic                             close_due,
	input  logic                             flush_deferred,
	input  logic                             keepalive_due,
	input  logic                             stale_due,
	input  logic                             remove_due,
	output int unsigned                      mismatches,
	output int unsigned                      outstanding
);

	typedef logic [lsts_pkg::TimeWidth-1:0] ms_t;

	typedef struct packed {
		logic close_due;
		logic flush_deferred;
		logic keepalive_due;
		logic stale_due;
		logic remove_due;
	} decision_t;

	ms_t                              handshake_limit;
	ms_t                              idle_limit;
	ms_t                              lifetime_limit;
	ms_t                              stale_grace;
	ms_t                              closed_keep_limit;
	logic [lsts_pkg::FactorWidth-1:0] keepalive_factor;
	decision_t                        due_q [$];
	decision_t                        expected;
	int unsigned                      fail_count = 0;
	int unsigned                      in_flight = 0;

	assign mismatches  = fail_count;
	assign outstanding = in_flight;

	function automatic decision_t decide_session(logic [lsts_pkg::StateWidth-1:0] st,
			logic init, ms_t now, ms_t created, ms_t rx, ms_t tx, ms_t ka, ms_t period,
			ms_t stale_lim, ms_t rtt);
		ms_t       latest;
		ms_t       act_age;
		ms_t       in_age;
		ms_t       life_age;
		ms_t       out_age;
		ms_t       ka_age;
		ms_t       deadline;
		logic      aged_out;
		decision_t d;
		latest   = (rx > tx) ? rx : tx;
		act_age  = now - ((latest == '0) ? created : latest);
		in_age   = now - ((rx == '0) ? created : rx);
		life_age = now - created;
		out_age  = now - tx;
		ka_age   = now - ka;
		aged_out = (act_age > idle_limit) || (life_age > lifetime_limit);
		d = '0;
		case (st)
			lsts_pkg::LINK_PENDING, lsts_pkg::LINK_HANDSHAKE: begin
				d.close_due  = act_age > handshake_limit;
				d.remove_due = d.close_due;
			end
			lsts_pkg::LINK_ACTIVE: begin
				d.flush_deferred = 1'b1;
				d.keepalive_due  = init && (period != '0) &&
					(in_age >= period || out_age >= period) &&
					(ka == '0 || ka_age >= period);
				d.stale_due      = (stale_lim != '0) && (in_age >= stale_lim);
				d.remove_due     = aged_out;
			end
			lsts_pkg::LINK_STALE: begin
				deadline     = stale_lim + rtt * ms_t'(keepalive_factor) + stale_grace;
				d.close_due  = in_age >= deadline;
				d.remove_due = act_age > idle_limit;
			end
			lsts_pkg::LINK_CLOSED: begin
				d.remove_due = act_age > closed_keep_limit;
			end
			default: begin
				d.close_due  = aged_out;
				d.remove_due = aged_out;
			end
		endcase
		return d;
	endfunction

	function automatic void check_flag(string name, logic want, logic got);
		if (got !== want) begin
			$error("%s: expected %0b, actual %0b", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handshake_limit   <= '0;
			idle_limit        <= '0;
			lifetime_limit    <= '0;
			stale_grace       <= '0;
			keepalive_factor  <= '0;
			closed_keep_limit <= '0;
			due_q.delete();
			in_flight <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lsts_pkg::CFG_HANDSHAKE_LIMIT:   handshake_limit   <= cfg_data;
					lsts_pkg::CFG_IDLE_LIMIT:        idle_limit        <= cfg_data;
					lsts_pkg::CFG_LIFETIME_LIMIT:    lifetime_limit    <= cfg_data;
					lsts_pkg::CFG_STALE_GRACE:       stale_grace       <= cfg_data;
					lsts_pkg::CFG_KEEPALIVE_FACTOR:
						keepalive_factor <= cfg_data[lsts_pkg::FactorWidth-1:0];
					lsts_pkg::CFG_CLOSED_KEEP_LIMIT: closed_keep_limit <= cfg_data;
					default: ;
				endcase
			end
			if (done) begin
				if (due_q.size() == 0) begin
					$error("Decision transfer arrived with no session record in flight.");
					fail_count++;
				end else begin
					expected = due_q.pop_front();
					check_flag("close_due", expected.close_due, close_due);
					check_flag("flush_deferred", expected.flush_deferred, flush_deferred);
					check_flag("keepalive_due", expected.keepalive_due, keepalive_due);
					check_flag("stale_due", expected.stale_due, stale_due);
					check_flag("remove_due", expected.remove_due, remove_due);
				end
			end
			if (start && !busy) begin
				due_q = {due_q, decide_session(link_state, is_initiator, time_now,
					time_created, last_rx_time, last_tx_time, last_keepalive_time,
					keepalive_period, stale_limit, round_trip_ms)};
			end
			in_flight <= due_q.size();
		end
	end

endmodule

// File: dv/link_session_timeout_supervisor_test.sv
module link_session_timeout_supervisor_test;

	localparam int unsigned CycleLimit    = 200000;
	localparam int unsigned PhaseCount    = 8;
	localparam int unsigned PhaseItems    = 150;
	localparam int unsigned QuietPhase    = 3;
	localparam int unsigned PressurePhase = 4;

	typedef logic [lsts_pkg::StateWidth-1:0] state_code_t;
	typedef logic [lsts_pkg::TimeWidth-1:0]  ms_t;

	// Codes outside the named states; the block treats them as other open states.
	localparam state_code_t LINK_RESERVED_A = 3'd6;
	localparam state_code_t LINK_RESERVED_B = 3'd7;

	typedef struct packed {
		state_code_t state;
		logic        initiator;
		ms_t         now;
		ms_t         created;
		ms_t         rx;
		ms_t         tx;
		ms_t         ka;
		ms_t         period;
		ms_t         stale;
		ms_t         rtt;
	} session_rec_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             start;
	logic                             busy;
	state_code_t                      link_state;
	logic                             is_initiator;
	ms_t                              time_now;
	ms_t                              time_created;
	ms_t                              last_rx_time;
	ms_t                              last_tx_time;
	ms_t                              last_keepalive_time;
	ms_t                              keepalive_period;
	ms_t                              stale_limit;
	ms_t                              round_trip_ms;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [lsts_pkg::CfgIdxWidth-1:0] cfg_index;
	ms_t                              cfg_data;
	logic                             done;
	logic                             close_due;
	logic                             flush_deferred;
	logic                             keepalive_due;
	logic                             stale_due;
	logic                             remove_due;
	int unsigned                      mismatches;
	int unsigned                      outstanding;
	int unsigned                      cycle_count = 0;
	session_rec_t                     directed [$];

	ms_t cur_handshake;
	ms_t cur_idle;
	ms_t cur_lifetime;
	ms_t cur_grace;
	ms_t cur_factor;
	ms_t cur_keep;

	link_session_timeout_supervisor DUT (.*);

	lsts_decision_checker monitor (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic void add_rec(state_code_t st, logic init, ms_t now, ms_t created,
			ms_t rx, ms_t tx, ms_t ka, ms_t period, ms_t stale, ms_t rtt);
		session_rec_t s;
		s.state     = st;
		s.initiator = init;
		s.now       = now;
		s.created   = created;
		s.rx        = rx;
		s.tx        = tx;
		s.ka        = ka;
		s.period    = period;
		s.stale     = stale;
		s.rtt       = rtt;
		directed    = {directed, s};
	endfunction

	// Ages mostly spread from 0 to 90000, sometimes placed at one of four limits or one off it.
	function automatic ms_t pick_age();
		ms_t limit;
		case ($urandom_range(0, 3))
			0: limit = cur_handshake;
			1: limit = cur_idle;
			2: limit = cur_lifetime;
			default: limit = cur_keep;
		endcase
		if ($urandom_range(0, 5) == 0)
			return limit + $urandom_range(0, 2) - 1;
		return $urandom_range(0, 90000);
	endfunction

	function automatic ms_t sometimes_never(ms_t stamp);
		return ($urandom_range(0, 4) == 0) ? '0 : stamp;
	endfunction

	function automatic session_rec_t make_session();
		session_rec_t s;
		s.state     = state_code_t'($urandom_range(0, 7));
		s.initiator = 1'($urandom_range(0, 1));
		s.now       = $urandom;
		s.created   = $urandom;
		s.rx        = $urandom;
		s.tx        = $urandom;
		s.ka        = $urandom;
		s.period    = $urandom;
		s.stale     = $urandom;
		s.rtt       = $urandom;
		if ($urandom_range(0, 4) != 0) begin
			if ($urandom_range(0, 9) != 0)
				s.state = state_code_t'($urandom_range(0, 5));
			s.created = s.now - pick_age();
			s.rx      = sometimes_never(s.now - pick_age());
			s.tx      = sometimes_never(s.now - pick_age());
			s.ka      = sometimes_never(s.now - pick_age());
			s.period  = ($urandom_range(0, 5) == 0) ? '0 : pick_age();
			s.stale   = ($urandom_range(0, 5) == 0) ? '0 : pick_age();
			s.rtt     = $urandom_range(0, 3000);
			if (s.state == lsts_pkg::LINK_STALE && $urandom_range(0, 3) == 0)
				s.rx = s.now - (s.stale + s.rtt * {16'd0, cur_factor[15:0]} + cur_grace)
					+ $urandom_range(0, 1);
		end
		return s;
	endfunction

	task automatic send(session_rec_t s);
		start               <= 1'b1;
		link_state          <= s.state;
		is_initiator        <= s.initiator;
		time_now            <= s.now;
		time_created        <= s.created;
		last_rx_time        <= s.rx;
		last_tx_time        <= s.tx;
		last_keepalive_time <= s.ka;
		keepalive_period    <= s.period;
		stale_limit         <= s.stale;
		round_trip_ms       <= s.rtt;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause(int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (lsts_pkg::Latency + 2) @(posedge clk);
	endtask

	task automatic write_reg(lsts_pkg::cfg_index_t idx, ms_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic configure(ms_t hs, ms_t idle, ms_t life, ms_t grace, ms_t factor,
			ms_t keep);
		cur_handshake = hs;
		cur_idle      = idle;
		cur_lifetime  = life;
		cur_grace     = grace;
		cur_factor    = factor;
		cur_keep      = keep;
		write_reg(lsts_pkg::CFG_HANDSHAKE_LIMIT, hs);
		write_reg(lsts_pkg::CFG_IDLE_LIMIT, idle);
		write_reg(lsts_pkg::CFG_LIFETIME_LIMIT, life);
		write_reg(lsts_pkg::CFG_STALE_GRACE, grace);
		write_reg(lsts_pkg::CFG_KEEPALIVE_FACTOR, factor);
		write_reg(lsts_pkg::CFG_CLOSED_KEEP_LIMIT, keep);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		ms_t n;
		n = 32'd10000;
		arst_n              <= 1'b0;
		start               <= 1'b0;
		link_state          <= lsts_pkg::LINK_PENDING;
		is_initiator        <= 1'b0;
		time_now            <= '0;
		time_created        <= '0;
		last_rx_time        <= '0;
		last_tx_time        <= '0;
		last_keepalive_time <= '0;
		keepalive_period    <= '0;
		stale_limit         <= '0;
		round_trip_ms       <= '0;
		cfg_valid           <= 1'b0;
		cfg_index           <= lsts_pkg::CFG_HANDSHAKE_LIMIT;
		cfg_data            <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(32'd1000, 32'd5000, 32'd60000, 32'd200, 32'd4, 32'd3000);
		add_rec(lsts_pkg::LINK_PENDING, 1'b0, n, 9000, 0, 0, 0, 0, 0, 0);
		add_rec(lsts_pkg::LINK_PENDING, 1'b1, n, 8999, 0, 0, 0, 0, 0, 0);
		add_rec(lsts_pkg::LINK_HANDSHAKE, 1'b0, n, 1, 9500, 9200, 0, 0, 0, 0);
		add_rec(lsts_pkg::LINK_HANDSHAKE, 1'b0, 100, 32'hFFFF_FF00, 0, 0, 0, 0, 0, 0);
		add_rec(lsts_pkg::LINK_ACTIVE, 1'b1, n, 5000, 9000, 9500, 0, 1000, 5000, 0);
		add_rec(lsts_pkg::LINK_ACTIVE, 1'b1, n, 5000, 9000, 9500, 9500, 1000, 5000, 0);
		add_rec(lsts_pkg::LINK_ACTIVE, 1'b0, n, 5000, 9000, 9500, 0, 1000, 5000, 0);
		add_rec(lsts_pkg::LINK_ACTIVE, 1'b1, n, 5000, 9000, 9500, 0, 0, 5000, 0);
		add_rec(lsts_pkg::LINK_ACTIVE, 1'b1, n, 5000, 9999, 0, 9000, 1000, 0, 0);
		add_rec(lsts_pkg::LINK_ACTIVE, 1'b0, n, 4000, 0, 9990, 0, 0, 6000, 0);
		add_rec(lsts_pkg::LINK_STALE, 1'b0, n, 5000, 6400, 9000, 0, 0, 3000, 100);
		add_rec(lsts_pkg::LINK_STALE, 1'b0, n, 5000, 6401, 9000, 0, 0, 3000, 100);
		add_rec(lsts_pkg::LINK_STALE, 1'b1, n, 5000, 9801, 0, 0, 0, 32'hFFFF_FFFF, 0);
		add_rec(lsts_pkg::LINK_STALE, 1'b0, n, 0, 0, 0, 0, 0, 3000, 32'hFFFF_FFFF);
		add_rec(lsts_pkg::LINK_CLOSED, 1'b0, n, 0, 6999, 0, 0, 0, 0, 0);
		add_rec(lsts_pkg::LINK_CLOSED, 1'b1, n, 0, 7000, 0, 0, 0, 0, 0);
		add_rec(lsts_pkg::LINK_OPEN, 1'b0, n, 4999, 0, 0, 0, 0, 0, 0);
		add_rec(lsts_pkg::LINK_OPEN, 1'b0, 70000, 9999, 69000, 69500, 0, 0, 0, 0);
		add_rec(lsts_pkg::LINK_OPEN, 1'b0, 70000, 10000, 69000, 69500, 0, 0, 0, 0);
		add_rec(LINK_RESERVED_A, 1'b0, n, 4999, 0, 0, 0, 0, 0, 0);
		add_rec(LINK_RESERVED_B, 1'b1, 70000, 10000, 69000, 69500, 0, 0, 0, 0);
		add_rec(lsts_pkg::LINK_PENDING, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_rec(lsts_pkg::LINK_OPEN, 1'b1, '1, '1, '1, '1, '1, '1, '1, '1);
		add_rec(lsts_pkg::LINK_ACTIVE, 1'b1, '1, '1, '1, '1, '1, '1, '1, '1);
		foreach (directed[i])
			send(directed[i]);

		for (int unsigned p = 1; p < PhaseCount; p++) begin
			drain();
			case (p)
				1: configure('1, '1, '1, '1, '1, '1);
				2: configure('0, '0, '0, '0, '0, '0);
				5: configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				default: configure($urandom_range(0, 20000), $urandom_range(0, 30000),
					$urandom_range(0, 80000), $urandom_range(0, 3000),
					$urandom_range(0, 16), $urandom_range(0, 30000));
			endcase
			for (int unsigned k = 0; k < PhaseItems; k++) begin
				if (p == PressurePhase && k == PhaseItems / 2)
					drain();
				else if (p != QuietPhase && $urandom_range(0, 99) < 6)
					pause($urandom_range(1, 4));
				send(make_session());
			end
		end

		drain();
		if (mismatches == 0 && outstanding == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
